// ----- rtl/gfmd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfmd_pkg
// Shared types and constants for the gyro fall / move detector.
// ----------------------------------------------------------------------------
package gfmd_pkg;

  localparam int RATE_WIDTH   = 16;
  localparam int WINDOW_DEF   = 5;
  localparam int THR_W        = 16;
  localparam int HIT_LIM_W    = 3;
  localparam int HIT_OUT_W    = 3;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;

  localparam logic [THR_W-1:0]     FALL_THR_RST   = THR_W'(512);
  localparam logic [THR_W-1:0]     MOVE_THR_RST   = THR_W'(51);
  localparam logic [HIT_LIM_W-1:0] FALL_LIM_RST   = HIT_LIM_W'(3);
  localparam logic [HIT_LIM_W-1:0] MOVE_LIM_RST   = HIT_LIM_W'(2);

  localparam logic [CFG_IDX_W-1:0] CFG_FALL_THR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MOVE_THR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FALL_LIM = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MOVE_LIM = 2'd3;

  typedef struct packed {
    logic signed [RATE_WIDTH-1:0] rate_x;
    logic signed [RATE_WIDTH-1:0] rate_y;
    logic signed [RATE_WIDTH-1:0] rate_z;
  } gfmd_in_t;

  typedef struct packed {
    logic                 fall_detected;
    logic                 move_detected;
    logic [HIT_OUT_W-1:0] fall_hits;
    logic [HIT_OUT_W-1:0] move_hits;
    logic                 primed;
  } gfmd_out_t;

  typedef struct packed {
    logic vld;
    logic fall;
    logic move;
  } gfmd_hit_t;

endpackage

// ----- rtl/gfmd_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfmd_ram
// Generic single-clock RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module gfmd_ram #(
  parameter int WIDTH  = 48,
  parameter int DEPTH  = 5,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/gfmd_cmp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfmd_cmp
// Two-stage entry comparator: absolute axis differences, then the
// two-of-three threshold vote for fall and move.
// ----------------------------------------------------------------------------
module gfmd_cmp (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     ent_vld,
  input  gfmd_pkg::gfmd_in_t       entry,
  input  gfmd_pkg::gfmd_in_t       sample,
  input  logic [gfmd_pkg::THR_W-1:0] fall_thr,
  input  logic [gfmd_pkg::THR_W-1:0] move_thr,
  output gfmd_pkg::gfmd_hit_t      hit
);
  import gfmd_pkg::*;

  localparam int DW = RATE_WIDTH + 1;
  localparam int CW = (RATE_WIDTH > THR_W) ? RATE_WIDTH : THR_W;

  logic                  vld_r;
  logic [RATE_WIDTH-1:0] dx_r, dy_r, dz_r;
  logic [RATE_WIDTH-1:0] dx_nxt, dy_nxt, dz_nxt;
  logic                  fx, fy, fz, mx, my, mz;
  logic                  fall, move;

  function automatic logic [RATE_WIDTH-1:0] abs_diff(
    input logic signed [RATE_WIDTH-1:0] a,
    input logic signed [RATE_WIDTH-1:0] b
  );
    logic signed [DW-1:0] d;
    logic        [DW-1:0] m;
    d = {a[RATE_WIDTH-1], a} - {b[RATE_WIDTH-1], b};
    m = d[DW-1] ? DW'(-d) : DW'(d);
    return m[RATE_WIDTH-1:0];
  endfunction

  assign dx_nxt = abs_diff(entry.rate_x, sample.rate_x);
  assign dy_nxt = abs_diff(entry.rate_y, sample.rate_y);
  assign dz_nxt = abs_diff(entry.rate_z, sample.rate_z);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= ent_vld;
    end
    dx_r <= dx_nxt;
    dy_r <= dy_nxt;
    dz_r <= dz_nxt;
  end

  assign fx = CW'(dx_r) > CW'(fall_thr);
  assign fy = CW'(dy_r) > CW'(fall_thr);
  assign fz = CW'(dz_r) > CW'(fall_thr);
  assign mx = CW'(dx_r) > CW'(move_thr);
  assign my = CW'(dy_r) > CW'(move_thr);
  assign mz = CW'(dz_r) > CW'(move_thr);

  assign fall = (fx & fy) | (fx & fz) | (fy & fz);
  assign move = !fall && ((mx & my) | (mx & mz) | (my & mz));

  assign hit.vld  = vld_r;
  assign hit.fall = vld_r & fall;
  assign hit.move = vld_r & move;

endmodule

// ----- rtl/gyro_fall_move_detector.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gyro_fall_move_detector
// Once the ring is full, each result is valid after a walk over the
// single-read history memory and the two-stage comparator; while the ring
// fills, the result comes without a walk. One item at a time: no new sample
// is accepted until the last result has gone into the output register, which
// waits while out_ready holds back a pending result. Reset empties the ring and
// restores the default thresholds and limits; the history memory is not cleared.
// ----------------------------------------------------------------------------
module gyro_fall_move_detector #(
  parameter int WINDOW = gfmd_pkg::WINDOW_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  gfmd_pkg::gfmd_in_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output gfmd_pkg::gfmd_out_t             out_data,
  input  logic                            cfg_we,
  input  logic [gfmd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gfmd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import gfmd_pkg::*;

  localparam int SLOT_W = $clog2(WINDOW);
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int CMP_W  = (CNT_W > HIT_LIM_W) ? CNT_W : HIT_LIM_W;
  localparam int EXT_W  = (CMP_W > HIT_OUT_W) ? CMP_W : HIT_OUT_W;
  localparam int MEM_W  = $bits(gfmd_in_t);
  localparam logic [SLOT_W-1:0] LAST = SLOT_W'(WINDOW - 1);
  localparam logic [CNT_W-1:0]  FULL = CNT_W'(WINDOW);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DONE
  } state_t;

  state_t                 state_r, state_nxt;
  gfmd_in_t               samp_r, samp_nxt;
  logic [SLOT_W-1:0]      idx_r, idx_nxt;
  logic [SLOT_W-1:0]      slot_r, slot_nxt;
  logic [CNT_W-1:0]       fill_r, fill_nxt;
  logic [CNT_W-1:0]       fall_cnt_r, fall_cnt_nxt;
  logic [CNT_W-1:0]       move_cnt_r, move_cnt_nxt;
  logic                   primed_r, primed_nxt;
  logic                   rd_vld_r, rd_vld_nxt;
  logic                   out_valid_r, out_valid_nxt;
  gfmd_out_t              out_data_r, out_data_nxt;
  logic [THR_W-1:0]       fall_thr_r, fall_thr_nxt;
  logic [THR_W-1:0]       move_thr_r, move_thr_nxt;
  logic [HIT_LIM_W-1:0]   fall_lim_r, fall_lim_nxt;
  logic [HIT_LIM_W-1:0]   move_lim_r, move_lim_nxt;

  logic                   rd_en, wr_en;
  logic [MEM_W-1:0]       rd_data;
  gfmd_hit_t              hit;
  logic                   accept;
  logic                   fall_det, move_det;
  logic [EXT_W-1:0]       fall_ext, move_ext;

  gfmd_ram #(
    .WIDTH  (MEM_W),
    .DEPTH  (WINDOW),
    .ADDR_W (SLOT_W)
  ) u_hist (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (slot_r),
    .wr_data (samp_r),
    .rd_en   (rd_en),
    .rd_addr (idx_r),
    .rd_data (rd_data)
  );

  gfmd_cmp u_cmp (
    .clk      (clk),
    .rst_n    (rst_n),
    .ent_vld  (rd_vld_r),
    .entry    (gfmd_in_t'(rd_data)),
    .sample   (samp_r),
    .fall_thr (fall_thr_r),
    .move_thr (move_thr_r),
    .hit      (hit)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign fall_det = primed_r && (CMP_W'(fall_cnt_r) > CMP_W'(fall_lim_r));
  assign move_det = primed_r && !fall_det && (CMP_W'(move_cnt_r) > CMP_W'(move_lim_r));
  assign fall_ext = EXT_W'(fall_cnt_r);
  assign move_ext = EXT_W'(move_cnt_r);

  always_comb begin
    fall_thr_nxt = fall_thr_r;
    move_thr_nxt = move_thr_r;
    fall_lim_nxt = fall_lim_r;
    move_lim_nxt = move_lim_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_FALL_THR: fall_thr_nxt = cfg_data[THR_W-1:0];
        CFG_MOVE_THR: move_thr_nxt = cfg_data[THR_W-1:0];
        CFG_FALL_LIM: fall_lim_nxt = cfg_data[HIT_LIM_W-1:0];
        CFG_MOVE_LIM: move_lim_nxt = cfg_data[HIT_LIM_W-1:0];
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    samp_nxt      = samp_r;
    idx_nxt       = idx_r;
    slot_nxt      = slot_r;
    fill_nxt      = fill_r;
    fall_cnt_nxt  = fall_cnt_r;
    move_cnt_nxt  = move_cnt_r;
    primed_nxt    = primed_r;
    rd_vld_nxt    = 1'b0;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    rd_en         = 1'b0;
    wr_en         = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (hit.vld) begin
      fall_cnt_nxt = fall_cnt_r + CNT_W'(hit.fall);
      move_cnt_nxt = move_cnt_r + CNT_W'(hit.move);
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          samp_nxt     = in_data;
          idx_nxt      = '0;
          fall_cnt_nxt = '0;
          move_cnt_nxt = '0;
          if (fill_r == FULL) begin
            primed_nxt = 1'b1;
            state_nxt  = S_SCAN;
          end else begin
            primed_nxt = 1'b0;
            fill_nxt   = fill_r + CNT_W'(1);
            state_nxt  = S_DONE;
          end
        end
      end
      S_SCAN: begin
        rd_en      = 1'b1;
        rd_vld_nxt = 1'b1;
        idx_nxt    = idx_r + SLOT_W'(1);
        if (idx_r == LAST) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!rd_vld_r && !hit.vld) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          wr_en                      = 1'b1;
          out_valid_nxt              = 1'b1;
          out_data_nxt.fall_detected = fall_det;
          out_data_nxt.move_detected = move_det;
          out_data_nxt.fall_hits     = fall_ext[HIT_OUT_W-1:0];
          out_data_nxt.move_hits     = move_ext[HIT_OUT_W-1:0];
          out_data_nxt.primed        = primed_r;
          slot_nxt                   = (slot_r == LAST) ? '0 : slot_r + SLOT_W'(1);
          state_nxt                  = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      slot_r      <= '0;
      fill_r      <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      fall_thr_r  <= FALL_THR_RST;
      move_thr_r  <= MOVE_THR_RST;
      fall_lim_r  <= FALL_LIM_RST;
      move_lim_r  <= MOVE_LIM_RST;
    end else begin
      state_r     <= state_nxt;
      slot_r      <= slot_nxt;
      fill_r      <= fill_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
      fall_thr_r  <= fall_thr_nxt;
      move_thr_r  <= move_thr_nxt;
      fall_lim_r  <= fall_lim_nxt;
      move_lim_r  <= move_lim_nxt;
    end
    samp_r     <= samp_nxt;
    idx_r      <= idx_nxt;
    fall_cnt_r <= fall_cnt_nxt;
    move_cnt_r <= move_cnt_nxt;
    primed_r   <= primed_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
